### rtl/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH_DEFAULT   = 16;
    localparam int ID_BITS_DEFAULT = 16;

    localparam int PORT_ID_W = 16;
    localparam int PRIO_W    = 3;
    localparam int STATUS_W  = 2;

    typedef logic [PRIO_W-1:0] prio_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ENQ   = 2'd0,
        STATUS_DEQ   = 2'd1,
        STATUS_EMPTY = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    // Operation broadcast to every cell of the chain in the same cycle
    typedef struct packed {
        logic insert;
        logic remove;
    } spq_op_t;

endpackage

### rtl/spq_cell.sv
module spq_cell #(
    parameter int ID_BITS = spq_pkg::ID_BITS_DEFAULT
) (
    input  logic                 clk,
    input  spq_pkg::spq_op_t     op,
    input  logic                 valid,
    input  logic [ID_BITS-1:0]   new_id,
    input  spq_pkg::prio_t       new_prio,
    input  logic                 left_keep,
    input  logic [ID_BITS-1:0]   left_id,
    input  spq_pkg::prio_t       left_prio,
    input  logic [ID_BITS-1:0]   right_id,
    input  spq_pkg::prio_t       right_prio,
    output logic                 keep,
    output logic [ID_BITS-1:0]   id,
    output spq_pkg::prio_t       prio
);
    import spq_pkg::*;

    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;
    prio_t              prio_reg;
    prio_t              prio_next;

    // An entry stays put when it is at least as urgent as the new one
    assign keep = valid && (prio_reg >= new_prio);

    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (op.insert && !keep)
        begin
            if (left_keep)
            begin
                id_next   = new_id;
                prio_next = new_prio;
            end
            else
            begin
                id_next   = left_id;
                prio_next = left_prio;
            end
        end
        else if (op.remove)
        begin
            id_next   = right_id;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign id   = id_reg;
    assign prio = prio_reg;

endmodule

### rtl/stable_priority_queue.sv
// Sorted ready queue of DEPTH entries, highest priority first, equal priorities
// in arrival order. Issue a command by raising start with kind, item_id and
// item_priority; busy is always low, so a command is taken in every cycle and
// back-to-back commands run at one per clock. Exactly one result follows each
// command in the next cycle, as a single-cycle pulse on done with status,
// head_id and head_priority. The receiver cannot stall: sample the result in
// the cycle done is high, it is not held. The entries live in a chain of
// cells; every cell compares the incoming priority in the same cycle and
// either holds, loads the new entry, or shifts from its neighbor, which is
// what sets the one-cycle rate. An enqueue on a full queue is dropped with
// status full; a dequeue on an empty queue reports empty. head_id and
// head_priority are zero unless status is dequeued.
module stable_priority_queue #(
    parameter int DEPTH   = spq_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = spq_pkg::ID_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [spq_pkg::PORT_ID_W-1:0]   item_id,
    input  logic [spq_pkg::PRIO_W-1:0]      item_priority,
    output logic                            done,
    output logic [spq_pkg::STATUS_W-1:0]    status,
    output logic [spq_pkg::PORT_ID_W-1:0]   head_id,
    output logic [spq_pkg::PRIO_W-1:0]      head_priority
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    status_t            status_reg;
    status_t            status_next;
    logic [ID_BITS-1:0] hid_reg;
    logic [ID_BITS-1:0] hid_next;
    prio_t              hprio_reg;
    prio_t              hprio_next;

    logic               take;
    logic               full;
    logic               empty;
    spq_op_t            op;
    logic [ID_BITS-1:0] new_id;

    logic               cell_keep [DEPTH];
    logic [ID_BITS-1:0] cell_id   [DEPTH];
    prio_t              cell_prio [DEPTH];

    // Commands never wait
    assign busy  = 1'b0;
    assign take  = start && !busy;
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign op.insert = take && (kind == KIND_ENQ) && !full;
    assign op.remove = take && (kind == KIND_DEQ) && !empty;

    // Keep the id modulo 2^ID_BITS
    generate
        if (ID_BITS >= PORT_ID_W)
        begin : g_id_wide
            assign new_id  = {{(ID_BITS - PORT_ID_W){1'b0}}, item_id};
            assign head_id = hid_reg[PORT_ID_W-1:0];
        end
        else
        begin : g_id_narrow
            assign new_id  = item_id[ID_BITS-1:0];
            assign head_id = {{(PORT_ID_W - ID_BITS){1'b0}}, hid_reg};
        end
    endgenerate

    // Chain of cells: cell 0 is the head
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic               left_keep;
            logic [ID_BITS-1:0] left_id;
            prio_t              left_prio;
            logic [ID_BITS-1:0] right_id;
            prio_t              right_prio;

            if (i == 0)
            begin : g_head
                // Nothing ahead of the head: a non-keeping head takes the new entry
                assign left_keep = 1'b1;
                assign left_id   = new_id;
                assign left_prio = item_priority;
            end
            else
            begin : g_body
                assign left_keep = cell_keep[i-1];
                assign left_id   = cell_id[i-1];
                assign left_prio = cell_prio[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                // The tail slot goes out of range on a dequeue; contents don't matter
                assign right_id   = cell_id[i];
                assign right_prio = cell_prio[i];
            end
            else
            begin : g_mid
                assign right_id   = cell_id[i+1];
                assign right_prio = cell_prio[i+1];
            end

            spq_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .clk        (clk),
                .op         (op),
                .valid      (CNT_W'(i) < count_reg),
                .new_id     (new_id),
                .new_prio   (item_priority),
                .left_keep  (left_keep),
                .left_id    (left_id),
                .left_prio  (left_prio),
                .right_id   (right_id),
                .right_prio (right_prio),
                .keep       (cell_keep[i]),
                .id         (cell_id[i]),
                .prio       (cell_prio[i])
            );
        end
    endgenerate

    // Occupancy and result register
    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        hid_next    = '0;
        hprio_next  = '0;
        if (op.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.remove)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (take)
        begin
            case (kind)
                KIND_ENQ:
                begin
                    status_next = full ? STATUS_FULL : STATUS_ENQ;
                end
                KIND_DEQ:
                begin
                    status_next = empty ? STATUS_EMPTY : STATUS_DEQ;
                    if (!empty)
                    begin
                        hid_next   = cell_id[0];
                        hprio_next = cell_prio[0];
                    end
                end
                default:
                begin
                    status_next = STATUS_ENQ;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        hid_reg    <= hid_next;
        hprio_reg  <= hprio_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign head_priority = hprio_reg;

    // Occupancy never runs past the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    // Every taken command yields exactly one result on the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> done)
        else $error("missing result transfer");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> !done)
        else $error("result without command");

    // A successful enqueue grows the queue by one and reports enqueued
    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        op.insert |=> (count_reg == $past(count_reg) + CNT_W'(1))
                      && (status_reg == STATUS_ENQ))
        else $error("enqueue bookkeeping mismatch");

    // Head stays at least as urgent as the entry behind it
    a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_prio[0] >= cell_prio[1]))
        else $error("head out of priority order");

endmodule

### verif/tb_top.sv
module tb_top;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
    localparam int RAND_ITEMS  = 1850;
    localparam int NUM_PHASES  = 4;
    localparam int CHUNK_ITEMS = 40;
    // Give up only far beyond the slowest legal run, even with the longest
    // sender gaps.
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;
    localparam int DIR_ROWS    = 25;

    // One result of the queue as it should appear on the result ports
    typedef struct {
        status_t                status;
        logic [PORT_ID_W-1:0]   id;
        prio_t                  prio;
    } result_t;

    // One row of the directed table. Where typed is set, the expected result
    // in the row is used as is; otherwise the predictor supplies it.
    typedef struct {
        kind_t                  kind;
        logic [PORT_ID_W-1:0]   id;
        prio_t                  prio;
        bit                     typed;
        status_t                status;
        logic [PORT_ID_W-1:0]   head_id;
        prio_t                  head_prio;
    } cmd_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   kind;
    logic [PORT_ID_W-1:0]   item_id;
    logic [PRIO_W-1:0]      item_priority;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [PORT_ID_W-1:0]   head_id;
    logic [PRIO_W-1:0]      head_priority;

    // Side information that travels with each command, sampled at its transfer
    bit                     cmd_typed;
    result_t                cmd_typed_result;

    // Predictor state: the entries in service order, slot 0 is the head
    logic [PORT_ID_W-1:0]   ready_ids   [QUEUE_DEPTH];
    prio_t                  ready_prios [QUEUE_DEPTH];
    int                     ready_count;

    // Results still owed by the block, oldest first
    result_t                pending_results [$];
    int                     error_count;
    int                     cycle_count;

    // Directed table: empty dequeue after reset, a fill with priority ties and
    // the out-of-range priorities zero and seven, the full case, then a
    // partial drain with a refill in between.
    cmd_row_t dir_table [DIR_ROWS] = '{
        '{KIND_DEQ, 16'hAAAA, 3'd5, 1'b1, STATUS_EMPTY, 16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0001, 3'd3, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0002, 3'd3, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0000, 3'd0, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0003, 3'd5, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'hFFFF, 3'd7, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0004, 3'd1, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0005, 3'd5, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0006, 3'd2, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0007, 3'd4, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0008, 3'd6, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h0009, 3'd3, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h5555, 3'd1, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'hAAAA, 3'd0, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h000A, 3'd7, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h000B, 3'd5, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h000C, 3'd4, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h1234, 3'd7, 1'b1, STATUS_FULL,  16'h0000, 3'd0},
        '{KIND_DEQ, 16'h0000, 3'd0, 1'b1, STATUS_DEQ,   16'hFFFF, 3'd7},
        '{KIND_DEQ, 16'hFFFF, 3'd7, 1'b0, STATUS_DEQ,   16'h0000, 3'd0},
        '{KIND_DEQ, 16'h0000, 3'd0, 1'b0, STATUS_DEQ,   16'h0000, 3'd0},
        '{KIND_ENQ, 16'h00FF, 3'd6, 1'b0, STATUS_ENQ,   16'h0000, 3'd0},
        '{KIND_DEQ, 16'h0000, 3'd0, 1'b0, STATUS_DEQ,   16'h0000, 3'd0},
        '{KIND_DEQ, 16'h0000, 3'd0, 1'b0, STATUS_DEQ,   16'h0000, 3'd0},
        '{KIND_DEQ, 16'h0000, 3'd0, 1'b0, STATUS_DEQ,   16'h0000, 3'd0}
    };

    // Sender idle percentage per phase: none, heavy, light, then none again
    int phase_idle_pct [NUM_PHASES] = '{0, 64, 20, 0};

    stable_priority_queue u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .item_id       (item_id),
        .item_priority (item_priority),
        .done          (done),
        .status        (status),
        .head_id       (head_id),
        .head_priority (head_priority)
    );

    always #6 clk = ~clk;

    // Apply one command to the predicted queue and return the result it owes.
    // Enqueue: insert after every entry of equal or higher priority, so ties
    // leave in arrival order. Dequeue: pop slot 0 and close the gap.
    function automatic result_t queue_step_result(kind_t k, logic [PORT_ID_W-1:0] id,
                                                  prio_t p);
        result_t r;
        int      pos;
        r.status = STATUS_ENQ;
        r.id     = '0;
        r.prio   = '0;
        pos      = 0;
        if (k == KIND_ENQ) begin
            if (ready_count >= QUEUE_DEPTH) begin
                r.status = STATUS_FULL;
            end
            else begin
                while (pos < ready_count && ready_prios[pos] >= p)
                    pos++;
                for (int i = ready_count; i > pos; i--) begin
                    ready_ids[i]   = ready_ids[i-1];
                    ready_prios[i] = ready_prios[i-1];
                end
                ready_ids[pos]   = id;
                ready_prios[pos] = p;
                ready_count++;
            end
        end
        else begin
            if (ready_count == 0) begin
                r.status = STATUS_EMPTY;
            end
            else begin
                r.status = STATUS_DEQ;
                r.id     = ready_ids[0];
                r.prio   = ready_prios[0];
                for (int i = 1; i < ready_count; i++) begin
                    ready_ids[i-1]   = ready_ids[i];
                    ready_prios[i-1] = ready_prios[i];
                end
                ready_count--;
            end
        end
        return r;
    endfunction

    // Drive one command and hold it until the block takes it. Afterwards,
    // drop start for a short random gap when the phase asks for idling;
    // otherwise leave start high so the next command follows back to back.
    task automatic issue_cmd(input kind_t k, input logic [PORT_ID_W-1:0] id,
                             input prio_t p, input bit typed, input result_t typed_res,
                             input int idle_pct);
        start            <= 1'b1;
        kind             <= k;
        item_id          <= id;
        item_priority    <= p;
        cmd_typed        <= typed;
        cmd_typed_result <= typed_res;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // Stimulus: reset, the directed table, then random phases
    initial begin : stimulus
        result_t no_result;
        kind_t   k;
        prio_t   p;
        int      enq_pct;
        int      items_left;
        int      phase_items;

        no_result.status = STATUS_ENQ;
        no_result.id     = '0;
        no_result.prio   = '0;

        rst_n            = 1'b0;
        start            = 1'b0;
        kind             = KIND_ENQ;
        item_id          = '0;
        item_priority    = '0;
        cmd_typed        = 1'b0;
        cmd_typed_result = no_result;

        // Hold reset, then release it on a rising edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table with no idling
        for (int r = 0; r < DIR_ROWS; r++) begin
            no_result.status = dir_table[r].status;
            no_result.id     = dir_table[r].head_id;
            no_result.prio   = dir_table[r].head_prio;
            issue_cmd(dir_table[r].kind, dir_table[r].id, dir_table[r].prio,
                      dir_table[r].typed, no_result, 0);
        end

        // Random part. Each chunk draws its own enqueue bias, so the queue
        // keeps swinging between empty and full and both edge cases recur.
        items_left  = RAND_ITEMS;
        phase_items = RAND_ITEMS / NUM_PHASES + 1;
        enq_pct     = 50;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            for (int n = 0; n < phase_items && items_left > 0; n++) begin
                if (n % CHUNK_ITEMS == 0)
                    enq_pct = $urandom_range(85, 15);
                k = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
                // Mostly legal priorities, with some zero, six and seven
                if ($urandom_range(99) < 85)
                    p = prio_t'($urandom_range(5, 1));
                else
                    p = prio_t'($urandom_range(7));
                issue_cmd(k, PORT_ID_W'($urandom), p, 1'b0, no_result,
                          phase_idle_pct[ph]);
                items_left--;
            end
        end
        start <= 1'b0;

        // Drain: wait for every owed result, then keep watching for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Scoreboard. At each rising edge, first record the expectation for a
    // command transferred at this edge, then check a result that is marked
    // by done, against the oldest expectation.
    always @(posedge clk) begin : scoreboard
        result_t predicted;
        result_t want;
        if (rst_n) begin
            if (start && !busy) begin
                predicted = queue_step_result(kind_t'(kind), item_id, item_priority);
                if (cmd_typed)
                    pending_results.push_back(cmd_typed_result);
                else
                    pending_results.push_back(predicted);
            end
            if (done) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: status %0d head_id %h",
                           status, head_id);
                    error_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        error_count++;
                    end
                    if (head_id !== want.id) begin
                        $error("head_id: expected %h, actual %h", want.id, head_id);
                        error_count++;
                    end
                    if (head_priority !== want.prio) begin
                        $error("head_priority: expected %0d, actual %0d",
                               want.prio, head_priority);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        ready_count = 0;
    end

endmodule

### stable_priority_queue.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
verif/tb_top.sv
